@@ rtl/core/wrcm_pkg.sv @@
// Shared constants and types of the windowed RMS current monitor.
package wrcm_pkg;

  localparam int WINDOW_LEN_DEF   = 16;
  localparam int SENSOR_COUNT_DEF = 12;

  localparam int SENSOR_W = 4;
  localparam int SAMPLE_W = 10;
  localparam int RMS_W    = 14;
  localparam int FRAC_W   = 4;

  // square of one sample, and the signed difference of two squares
  localparam int SQ_W    = 2 * SAMPLE_W;
  localparam int DELTA_W = SQ_W + 1;

  // window mean never exceeds the largest square
  localparam int MEAN_W = SQ_W;
  localparam int RAD_W  = MEAN_W + 2 * FRAC_W;

  typedef enum logic [0:0] {
    OP_STORE  = 1'b0,
    OP_REPORT = 1'b1
  } opcode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ rtl/core/wrcm_if.sv @@
// Valid/ready channels for sample and report words and for RMS result words.
interface wrcm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [wrcm_pkg::SENSOR_W-1:0] sensor;
  logic [wrcm_pkg::SAMPLE_W-1:0] sample;
  logic                          new_set;

  modport source (output valid, output opcode, output sensor, output sample,
                  output new_set, input ready);
  modport sink   (input valid, input opcode, input sensor, input sample,
                  input new_set, output ready);
endinterface

interface wrcm_out_if;
  logic                          valid;
  logic                          ready;
  logic [wrcm_pkg::SENSOR_W-1:0] sensor_out;
  logic [wrcm_pkg::RMS_W-1:0]    rms;
  logic                          last;

  modport source (output valid, output sensor_out, output rms, output last,
                  input ready);
  modport sink   (input valid, input sensor_out, input rms, input last,
                  output ready);
endinterface

@@ rtl/core/wrcm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wrcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/wrcm_sqdiff.sv @@
// Bit-serial unit that forms new*new - old*old for one sample replacement.
module wrcm_sqdiff (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [wrcm_pkg::SAMPLE_W-1:0]       old_val,
  input  logic [wrcm_pkg::SAMPLE_W-1:0]       new_val,
  output wrcm_pkg::unit_sts_t                 sts,
  output logic signed [wrcm_pkg::DELTA_W-1:0] delta
);

  localparam int SW = wrcm_pkg::SAMPLE_W;
  localparam int QW = wrcm_pkg::SQ_W;
  localparam int DW = wrcm_pkg::DELTA_W;
  localparam int CW = $clog2(SW);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [SW-1:0]        mul_new_r;
  logic [SW-1:0]        mul_old_r;
  logic [QW-1:0]        mcd_new_r;
  logic [QW-1:0]        mcd_old_r;
  logic signed [DW-1:0] acc_r;
  logic signed [DW-1:0] part_new;
  logic signed [DW-1:0] part_old;
  logic signed [DW-1:0] acc_nxt;

  // one multiplier bit of each square per cycle
  always_comb begin
    part_new = mul_new_r[0] ? $signed({1'b0, mcd_new_r}) : '0;
    part_old = mul_old_r[0] ? $signed({1'b0, mcd_old_r}) : '0;
    acc_nxt  = acc_r + part_new - part_old;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(SW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mul_new_r <= new_val;
      mul_old_r <= old_val;
      mcd_new_r <= QW'(new_val);
      mcd_old_r <= QW'(old_val);
      acc_r     <= '0;
    end else if (busy_r) begin
      mul_new_r <= mul_new_r >> 1;
      mul_old_r <= mul_old_r >> 1;
      mcd_new_r <= mcd_new_r << 1;
      mcd_old_r <= mcd_old_r << 1;
      acc_r     <= acc_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign delta    = acc_r;

endmodule

@@ rtl/core/wrcm_rms.sv @@
// Bit-serial divide by the window length followed by a radix-2 square root.
module wrcm_rms #(
  parameter int WINDOW_LEN = wrcm_pkg::WINDOW_LEN_DEF,
  parameter int SUM_W      = wrcm_pkg::SQ_W + $clog2(WINDOW_LEN)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [SUM_W-1:0]               sum_in,
  output wrcm_pkg::unit_sts_t            sts,
  output logic [wrcm_pkg::RMS_W-1:0]     root
);

  localparam int RW     = $clog2(WINDOW_LEN) + 1;
  localparam int MW     = wrcm_pkg::MEAN_W;
  localparam int AW     = wrcm_pkg::RAD_W;
  localparam int OW     = wrcm_pkg::RMS_W;
  localparam int SRW    = OW + 1;
  localparam int CNT_W  = $clog2(SUM_W);
  localparam int PAD_W  = 2 * wrcm_pkg::FRAC_W;

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_DIV  = 3'b010,
    R_SQRT = 3'b100
  } rstate_t;

  rstate_t          state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [SUM_W-1:0] num_r;
  logic [RW-1:0]    drem_r;
  logic [MW-1:0]    quo_r;
  logic [AW-1:0]    rad_r;
  logic [SRW-1:0]   srem_r;
  logic [OW-1:0]    root_r;

  logic [RW:0]      dtrial;
  logic             dge;
  logic [RW-1:0]    drem_nxt;
  logic [MW-1:0]    quo_nxt;
  logic [SRW+1:0]   sshift;
  logic [SRW+1:0]   strial;
  logic             sge;
  logic [SRW-1:0]   srem_nxt;
  logic [OW-1:0]    root_nxt;

  // restoring division: one quotient bit per cycle
  always_comb begin
    dtrial   = {drem_r, num_r[SUM_W-1]};
    dge      = dtrial >= (RW + 1)'(WINDOW_LEN);
    drem_nxt = dge ? RW'(dtrial - (RW + 1)'(WINDOW_LEN)) : RW'(dtrial);
    quo_nxt  = {quo_r[MW-2:0], dge};
  end

  // square root: bring down two radicand bits, settle one root bit
  always_comb begin
    sshift   = {srem_r, rad_r[AW-1 -: 2]};
    strial   = (SRW + 2)'({root_r, 2'b01});
    sge      = sshift >= strial;
    srem_nxt = sge ? SRW'(sshift - strial) : SRW'(sshift);
    root_nxt = {root_r[OW-2:0], sge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        R_IDLE: begin
          if (start) begin
            state_r <= R_DIV;
            cnt_r   <= '0;
          end
        end
        R_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(SUM_W - 1)) begin
            state_r <= R_SQRT;
            cnt_r   <= '0;
          end
        end
        R_SQRT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(OW - 1)) begin
            state_r <= R_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: begin
          state_r <= R_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      R_IDLE: begin
        if (start) begin
          num_r  <= sum_in;
          drem_r <= '0;
          quo_r  <= '0;
        end
      end
      R_DIV: begin
        num_r  <= num_r << 1;
        drem_r <= drem_nxt;
        quo_r  <= quo_nxt;
        if (cnt_r == CNT_W'(SUM_W - 1)) begin
          rad_r  <= {quo_nxt, {PAD_W{1'b0}}};
          srem_r <= '0;
          root_r <= '0;
        end
      end
      R_SQRT: begin
        rad_r  <= rad_r << 2;
        srem_r <= srem_nxt;
        root_r <= root_nxt;
      end
      default: begin
        num_r <= num_r;
      end
    endcase
  end

  assign sts.busy = (state_r != R_IDLE);
  assign sts.done = done_r;
  assign root     = root_r;

endmodule

@@ rtl/core/windowed_rms_current_monitor_top.sv @@
// Windowed RMS current monitor: sample ring store, running square sums, report sequencer.
//
// After reset the block sweeps its sample RAM to zero, one entry per cycle, over all
// SENSOR_COUNT*WINDOW_LEN entries, and takes no word until the sweep ends. A store word
// for a sensor in range passes through accept, RAM read, the bit-serial squarer that
// forms new*new - old*old, and the sum update; a store word for a sensor out of range is
// accepted and goes straight back to idle. A report word gives SENSOR_COUNT result words,
// each computed by the bit-serial divide by the window length and the 14-step square root
// that share one unit. A finished result waits in the output register while the next is
// computed.
module windowed_rms_current_monitor_top #(
  parameter int WINDOW_LEN   = wrcm_pkg::WINDOW_LEN_DEF,
  parameter int SENSOR_COUNT = wrcm_pkg::SENSOR_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wrcm_in_if.sink    in_ch,
  wrcm_out_if.source out_ch
);

  localparam int DEPTH   = SENSOR_COUNT * WINDOW_LEN;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SIDX_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int SUM_W   = wrcm_pkg::SQ_W + $clog2(WINDOW_LEN);
  localparam int DW      = wrcm_pkg::DELTA_W;
  localparam int EXT_W   = (SUM_W > DW) ? SUM_W : DW;
  localparam int SW      = wrcm_pkg::SAMPLE_W;
  localparam int SNW     = wrcm_pkg::SENSOR_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_SQ    = 7'b0001000,
    S_START = 7'b0010000,
    S_CALC  = 7'b0100000,
    S_PUSH  = 7'b1000000
  } state_t;

  state_t                       state_r;
  logic [AW-1:0]                clr_addr_r;
  logic [SLOT_W-1:0]            slot_r;
  logic [SIDX_W-1:0]            sensor_r;
  logic [AW-1:0]                addr_r;
  logic [SW-1:0]                sample_r;
  logic [SUM_W-1:0]             sum_r [SENSOR_COUNT];
  logic [SIDX_W-1:0]            k_r;
  logic                         out_valid_r;
  logic [SNW-1:0]               out_sensor_r;
  logic [wrcm_pkg::RMS_W-1:0]   out_rms_r;
  logic                         out_last_r;

  logic                         accept;
  logic                         is_store;
  logic                         in_range;
  logic [SLOT_W-1:0]            slot_adv;
  logic [SLOT_W-1:0]            slot_nxt;
  logic [AW-1:0]                in_addr;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [SW-1:0]                ram_wdata;
  logic                         ram_re;
  logic [SW-1:0]                ram_rdata;
  logic                         sq_start;
  wrcm_pkg::unit_sts_t          sq_sts;
  logic signed [DW-1:0]         sq_delta;
  logic signed [EXT_W-1:0]      delta_ext;
  logic                         rms_start;
  wrcm_pkg::unit_sts_t          rms_sts;
  logic [wrcm_pkg::RMS_W-1:0]   rms_root;
  logic                         k_last;
  logic                         push;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_store    = (in_ch.opcode == wrcm_pkg::OP_STORE);
  assign in_range    = {1'b0, in_ch.sensor} < (SNW + 1)'(SENSOR_COUNT);

  always_comb begin
    slot_adv = (slot_r == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_r + 1'b1;
    slot_nxt = (accept && is_store && in_ch.new_set) ? slot_adv : slot_r;
    in_addr  = AW'(32'(in_ch.sensor) * WINDOW_LEN + 32'(slot_nxt));
  end

  // sample RAM: sweep to zero after reset, otherwise read old sample then write new
  assign ram_re    = accept && is_store && in_range;
  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_READ);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : sample_r;

  wrcm_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  assign sq_start = (state_r == S_READ);

  wrcm_sqdiff u_sqdiff (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .old_val (ram_rdata),
    .new_val (sample_r),
    .sts     (sq_sts),
    .delta   (sq_delta)
  );

  assign delta_ext = EXT_W'(sq_delta);
  assign rms_start = (state_r == S_START);

  wrcm_rms #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_rms (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (rms_start),
    .sum_in (sum_r[k_r]),
    .sts    (rms_sts),
    .root   (rms_root)
  );

  assign k_last = (k_r == SIDX_W'(SENSOR_COUNT - 1));
  assign push   = (state_r == S_PUSH) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      slot_r      <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        sum_r[i] <= '0;
      end
    end else begin
      slot_r <= slot_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (!is_store) begin
              k_r     <= '0;
              state_r <= S_START;
            end else if (in_range) begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (sq_sts.done) begin
            sum_r[sensor_r] <= sum_r[sensor_r] + delta_ext[SUM_W-1:0];
            state_r         <= S_IDLE;
          end
        end
        S_START: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          if (rms_sts.done) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push) begin
            if (k_last) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_START;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // hold the store word's fields for the read-modify-write, and register each pushed result word
  always_ff @(posedge clk) begin
    if (ram_re) begin
      sensor_r <= SIDX_W'(in_ch.sensor);
      addr_r   <= in_addr;
      sample_r <= in_ch.sample;
    end
    if (push) begin
      out_sensor_r <= SNW'(k_r);
      out_rms_r    <= rms_root;
      out_last_r   <= k_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sensor_out = out_sensor_r;
  assign out_ch.rms        = out_rms_r;
  assign out_ch.last       = out_last_r;

  a_sq_done_in_sq: assert property (@(posedge clk) disable iff (!rst_n)
    sq_sts.done |-> state_r == S_SQ)
    else $error("squarer finished outside the sum update state");

  a_rms_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    rms_sts.done |-> state_r == S_CALC)
    else $error("root unit finished outside the report calculation");

  a_last_matches_sensor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_sensor_r == SNW'(SENSOR_COUNT - 1))))
    else $error("last flag does not match final sensor");

  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_W'(WINDOW_LEN - 1))
    else $error("write slot beyond window");

  a_no_output_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_valid_r)
    else $error("result word during clearing sweep");

endmodule

@@ verif/windowed_rms_current_monitor_top_tb.sv @@
// Self-checking testbench of the windowed RMS current monitor: sample sets, reports, stalls.
`timescale 1ns / 100ps

module windowed_rms_current_monitor_top_tb;

  localparam int WINDOW_LEN   = wrcm_pkg::WINDOW_LEN_DEF;
  localparam int SENSOR_COUNT = wrcm_pkg::SENSOR_COUNT_DEF;
  localparam int SENSOR_W     = wrcm_pkg::SENSOR_W;
  localparam int SAMPLE_W     = wrcm_pkg::SAMPLE_W;
  localparam int RMS_W        = wrcm_pkg::RMS_W;
  localparam int RAND_WORDS   = 155;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 64;
  localparam int HOT_SETS     = 17;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic [RMS_W-1:0]    rms;
    logic                last;
  } rms_word_t;

  // typed rows carry the RMS of sensor 0 and of all other sensors
  typedef struct {
    wrcm_pkg::opcode_t   op;
    logic [SENSOR_W-1:0] sensor;
    logic [SAMPLE_W-1:0] sample;
    logic                new_set;
    bit                  typed;
    logic [RMS_W-1:0]    rms_first;
    logic [RMS_W-1:0]    rms_rest;
  } dir_row_t;

  logic clk;
  logic rst_n;

  wrcm_in_if  in_ch ();
  wrcm_out_if out_ch ();

  windowed_rms_current_monitor_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic [SAMPLE_W-1:0] win_samples [SENSOR_COUNT][WINDOW_LEN];
  logic [23:0]         win_sq_sum  [SENSOR_COUNT];
  logic [3:0]          win_slot;
  rms_word_t           rms_pending [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_cnt;
  int stall_cycles;

  dir_row_t dir_rows [0:24] = '{
    '{wrcm_pkg::OP_REPORT, 4'd7,  10'd1023, 1'b1, 1'b1, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd12, 10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd15, 10'd682,  1'b0, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_REPORT, 4'd0,  10'd0,    1'b0, 1'b1, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd1023, 1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_REPORT, 4'd15, 10'd341,  1'b0, 1'b1, 14'd16368, 14'd0},
    '{wrcm_pkg::OP_STORE,  4'd11, 10'd1,    1'b0, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd0,  10'd0,    1'b0, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_STORE,  4'd5,  10'd341,  1'b1, 1'b0, 14'd0,     14'd0},
    '{wrcm_pkg::OP_REPORT, 4'd15, 10'd1023, 1'b1, 1'b0, 14'd0,     14'd0}
  };

  always #6 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < 50) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    mismatch_cnt++;
  endtask

  // Update the windows for one accepted word; queue the RMS words of a report.
  task automatic advance_windows(input wrcm_pkg::opcode_t op,
                                 input logic [SENSOR_W-1:0] sensor,
                                 input logic [SAMPLE_W-1:0] smp, input logic new_set);
    logic [SAMPLE_W-1:0] old;
    logic [27:0]         rad;
    logic [RMS_W-1:0]    root;
    logic [RMS_W-1:0]    trial;
    rms_word_t           w;
    if (op == wrcm_pkg::OP_STORE) begin
      if (new_set) begin
        win_slot = (win_slot == WINDOW_LEN - 1) ? 4'd0 : win_slot + 4'd1;
      end
      // out-of-range sensors only move the slot
      if (sensor < SENSOR_COUNT) begin
        old = win_samples[sensor][win_slot];
        win_sq_sum[sensor] = win_sq_sum[sensor] - 24'(old) * 24'(old)
                             + 24'(smp) * 24'(smp);
        win_samples[sensor][win_slot] = smp;
      end
    end else begin
      for (int k = 0; k < SENSOR_COUNT; k++) begin
        rad  = 28'(win_sq_sum[k] / WINDOW_LEN) << 8;
        root = '0;
        for (int b = RMS_W - 1; b >= 0; b--) begin
          trial = root | (14'd1 << b);
          if (longint'(trial) * longint'(trial) <= longint'(rad)) begin
            root = trial;
          end
        end
        w.sensor = SENSOR_W'(k);
        w.rms    = root;
        w.last   = (k == SENSOR_COUNT - 1);
        rms_pending.push_back(w);
      end
    end
  endtask

  task automatic send_word(input wrcm_pkg::opcode_t op, input logic [SENSOR_W-1:0] sensor,
                           input logic [SAMPLE_W-1:0] smp, input logic new_set);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.sensor  <= sensor;
    in_ch.sample  <= smp;
    in_ch.new_set <= new_set;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Hold the sender until every queued RMS word has come out.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (rms_pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 10'd1023;
    if (r < 25) return 10'd0;
    return SAMPLE_W'($urandom_range(1023));
  endfunction

  // RMS word checker and receiver stalls
  always @(posedge clk) begin : rms_check
    rms_word_t want;
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (rms_pending.size() == 0) begin
        report_mismatch($sformatf("unexpected RMS word sensor %0d rms %0d last %0b",
                                  out_ch.sensor_out, out_ch.rms, out_ch.last));
      end else begin
        want = rms_pending.pop_front();
        if (out_ch.sensor_out !== want.sensor) begin
          report_mismatch($sformatf("sensor_out %0d, want %0d", out_ch.sensor_out,
                                    want.sensor));
        end
        if (out_ch.rms !== want.rms) begin
          report_mismatch($sformatf("rms of sensor %0d is %0d, want %0d", want.sensor,
                                    out_ch.rms, want.rms));
        end
        if (out_ch.last !== want.last) begin
          report_mismatch($sformatf("last of sensor %0d is %0b, want %0b", want.sensor,
                                    out_ch.last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL windowed_rms_current_monitor_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    wrcm_pkg::opcode_t   op;
    logic [SENSOR_W-1:0] sensor;
    logic [SAMPLE_W-1:0] smp;
    logic                new_set;
    rms_word_t           w;
    int                  rand_words;
    int                  phase;
    int                  set_left;
    int                  set_cnt;
    bit                  hot_set;
    int                  pick;

    clk           = 1'b0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = wrcm_pkg::OP_STORE;
    in_ch.sensor  = '0;
    in_ch.sample  = '0;
    in_ch.new_set = 1'b0;
    out_ch.ready  = 1'b0;
    mismatch_cnt  = 0;
    stall_cycles  = 0;
    send_idle_pct = 29;
    recv_idle_pct = 53;
    win_slot      = '0;
    foreach (win_sq_sum[s]) begin
      win_sq_sum[s] = '0;
      foreach (win_samples[s][i]) win_samples[s][i] = '0;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].op, dir_rows[i].sensor, dir_rows[i].sample, dir_rows[i].new_set);
      if (dir_rows[i].typed) begin
        for (int k = 0; k < SENSOR_COUNT; k++) begin
          w.sensor = SENSOR_W'(k);
          w.rms    = (k == 0) ? dir_rows[i].rms_first : dir_rows[i].rms_rest;
          w.last   = (k == SENSOR_COUNT - 1);
          rms_pending.push_back(w);
        end
      end else begin
        advance_windows(dir_rows[i].op, dir_rows[i].sensor, dir_rows[i].sample,
                        dir_rows[i].new_set);
      end
    end

    // Random part: mostly sample sets led by a new-set word; the first sets drive
    // the top sensor to full scale on every slot.
    rand_words = 0;
    phase      = 0;
    set_left   = 0;
    set_cnt    = 0;
    hot_set    = 1'b0;
    while (rand_words < RAND_WORDS) begin
      if (rand_words * 3 / RAND_WORDS != phase && set_left == 0) begin
        wait_drained();
        phase = rand_words * 3 / RAND_WORDS;
        send_idle_pct = (phase == 1) ? 53 : 0;
        recv_idle_pct = (phase == 1) ? 29 : 0;
      end
      if (set_left == 0) begin
        pick    = $urandom_range(99);
        hot_set = (set_cnt < HOT_SETS);
        if (pick < 12) begin
          op      = wrcm_pkg::OP_REPORT;
          sensor  = SENSOR_W'($urandom_range(15));
          smp     = SAMPLE_W'($urandom_range(1023));
          new_set = 1'($urandom_range(1));
        end else if (pick < 22 && !hot_set) begin
          op      = wrcm_pkg::OP_STORE;
          sensor  = SENSOR_W'($urandom_range(15));
          smp     = draw_sample();
          new_set = 1'($urandom_range(1));
        end else begin
          set_left = $urandom_range(1, 4) - 1;
          set_cnt++;
          op       = wrcm_pkg::OP_STORE;
          new_set  = 1'b1;
          sensor   = hot_set ? SENSOR_W'(SENSOR_COUNT - 1)
                             : SENSOR_W'($urandom_range(SENSOR_COUNT - 1));
          smp      = hot_set ? 10'd1023 : draw_sample();
        end
      end else begin
        set_left--;
        op      = wrcm_pkg::OP_STORE;
        new_set = 1'b0;
        smp     = draw_sample();
        if (hot_set) begin
          sensor = SENSOR_W'($urandom_range(SENSOR_COUNT - 2));
        end else if ($urandom_range(19) == 0) begin
          sensor = SENSOR_W'($urandom_range(15, SENSOR_COUNT));
        end else begin
          sensor = SENSOR_W'($urandom_range(SENSOR_COUNT - 1));
        end
      end
      send_word(op, sensor, smp, new_set);
      advance_windows(op, sensor, smp, new_set);
      rand_words++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS windowed_rms_current_monitor_top");
    end else begin
      $display("FAIL windowed_rms_current_monitor_top");
    end
    $finish;
  end

endmodule
